### hdl/krat_pkg.sv
package krat_pkg;

  // table geometry
  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);

  // field widths
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned KEY_W   = 16;
  localparam int unsigned ELAP_W  = 32;
  localparam int unsigned TOTAL_W = 64;
  localparam int unsigned STAT_W  = 2;

  // request codes
  localparam logic [REQ_W-1:0] REQ_ACC   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SWEEP = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_MATCH = 2'd0;
  localparam logic [STAT_W-1:0] ST_NEW   = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;  // capture request, search table, start time read
    logic exec;  // update entry, register result
  } krat_cmd_t;

endpackage

### hdl/krat_if.sv
interface krat_in_if import krat_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [KEY_W-1:0]  task_key;
  logic [ELAP_W-1:0] elapsed_time;

  modport source (output valid, req_type, task_key, elapsed_time, input ready);
  modport sink   (input valid, req_type, task_key, elapsed_time, output ready);
endinterface

interface krat_out_if import krat_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] total_time;
  logic [STAT_W-1:0]  status;

  modport source (output valid, total_time, status, input ready);
  modport sink   (input valid, total_time, status, output ready);
endinterface

### hdl/krat_ram.sv
module krat_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/krat_ctrl.sv
module krat_ctrl import krat_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output krat_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  // a new word may enter while the previous result is being taken
  assign in_ready_o  = (state_q == S_IDLE) || ((state_q == S_OUT) && out_ready_i);
  assign out_valid_o = (state_q == S_OUT);
  assign accept      = in_valid_i && in_ready_o;

  assign cmd_o.load = accept;
  assign cmd_o.exec = (state_q == S_EXEC);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (accept)           state_d = S_EXEC;
        else if (out_ready_i) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hdl/krat_dp.sv
module krat_dp import krat_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  krat_cmd_t          cmd_i,
  input  logic [REQ_W-1:0]   req_type_i,
  input  logic [KEY_W-1:0]   task_key_i,
  input  logic [ELAP_W-1:0]  elapsed_time_i,
  output logic [TOTAL_W-1:0] total_time_o,
  output logic [STAT_W-1:0]  status_o
);

  // entry flags and keys in flops for the parallel compare
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
  logic [TABLE_ENTRIES-1:0] running_q, running_d;
  logic [KEY_W-1:0]         key_q [TABLE_ENTRIES];

  // captured request and search outcome
  logic [REQ_W-1:0]  req_q;
  logic [KEY_W-1:0]  tkey_q;
  logic [ELAP_W-1:0] elap_q;
  logic              hit_q, free_q;
  idx_t              hit_idx_q, free_idx_q;

  logic hit_c, free_c;
  idx_t hit_idx_c, free_idx_c;

  logic [TOTAL_W-1:0] time_rdata;
  logic [TOTAL_W-1:0] total_c;
  logic [STAT_W-1:0]  status_c;
  logic               we_c;
  idx_t               waddr_c;

  logic [TOTAL_W-1:0] total_q;
  logic [STAT_W-1:0]  status_q;

  // lowest valid match and lowest free entry
  always_comb begin
    hit_c      = 1'b0;
    free_c     = 1'b0;
    hit_idx_c  = '0;
    free_idx_c = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && (key_q[i] == task_key_i)) begin
        hit_c     = 1'b1;
        hit_idx_c = idx_t'(i);
      end
      if (!valid_q[i]) begin
        free_c     = 1'b1;
        free_idx_c = idx_t'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q      <= req_type_i;
      tkey_q     <= task_key_i;
      elap_q     <= elapsed_time_i;
      hit_q      <= hit_c;
      free_q     <= free_c;
      hit_idx_q  <= hit_idx_c;
      free_idx_q <= free_idx_c;
    end
  end

  // run time store, read at the match during the search cycle
  krat_ram #(
    .WIDTH (TOTAL_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (we_c),
    .waddr_i (waddr_c),
    .wdata_i (total_c),
    .raddr_i (hit_idx_c),
    .rdata_o (time_rdata)
  );

  // new total and status
  always_comb begin
    total_c  = '0;
    status_c = ST_MATCH;
    we_c     = 1'b0;
    waddr_c  = hit_q ? hit_idx_q : free_idx_q;
    if (req_q == REQ_ACC) begin
      priority if (hit_q) begin
        total_c  = time_rdata + {{(TOTAL_W-ELAP_W){1'b0}}, elap_q};
        status_c = ST_MATCH;
        we_c     = cmd_i.exec;
      end else if (free_q) begin
        total_c  = {{(TOTAL_W-ELAP_W){1'b0}}, elap_q};
        status_c = ST_NEW;
        we_c     = cmd_i.exec;
      end else begin
        total_c  = '0;
        status_c = ST_FULL;
      end
    end
  end

  // flag updates per request type
  always_comb begin
    valid_d   = valid_q;
    running_d = running_q;
    unique case (req_q)
      REQ_ACC: begin
        priority if (hit_q) begin
          running_d[hit_idx_q] = 1'b1;
        end else if (free_q) begin
          valid_d[free_idx_q]   = 1'b1;
          running_d[free_idx_q] = 1'b1;
        end else begin
          valid_d = valid_q;
        end
      end
      REQ_SWEEP: begin
        valid_d   = valid_q & running_q;
        running_d = '0;
      end
      REQ_CLEAR: begin
        valid_d   = '0;
        running_d = '0;
      end
      default: begin
        valid_d = valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      running_q <= '0;
    end else if (cmd_i.exec) begin
      valid_q   <= valid_d;
      running_q <= running_d;
    end
  end

  // key written on insert, result registered
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      if ((req_q == REQ_ACC) && !hit_q && free_q) begin
        key_q[free_idx_q] <= tkey_q;
      end
      total_q  <= total_c;
      status_q <= status_c;
    end
  end

  assign total_time_o = total_q;
  assign status_o     = status_q;

endmodule

### hdl/keyed_runtime_accumulator_table.sv
// a result word is offered from the output register once its request word has passed the load and exec steps
// no new word is taken during the exec step of the last; search plus time read, then add and write-back
// the run time store has one registered read port, which splits each word into these two steps
// reset: asynchronous active low, all entries invalid and unmarked at once, no clearing pass
// results wait in an output register and a new word enters as the last one is taken
module keyed_runtime_accumulator_table import krat_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  krat_in_if.sink    in_s,
  krat_out_if.source out_m
);

  krat_cmd_t cmd;

  krat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_s.valid),
    .in_ready_o  (in_s.ready),
    .out_valid_o (out_m.valid),
    .out_ready_i (out_m.ready),
    .cmd_o       (cmd)
  );

  krat_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .req_type_i     (in_s.req_type),
    .task_key_i     (in_s.task_key),
    .elapsed_time_i (in_s.elapsed_time),
    .total_time_o   (out_m.total_time),
    .status_o       (out_m.status)
  );

  // checks
  a_exec_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> cmd.exec && !out_m.valid)
    else $error("accepted word not executed in the next cycle");

  a_result_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec |=> out_m.valid)
    else $error("result not offered after execution");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_s.valid && in_s.ready) |-> (!out_m.valid || out_m.ready))
    else $error("new word accepted while result still pending");

  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_m.valid && (out_m.status == ST_FULL)) |-> (out_m.total_time == '0))
    else $error("dropped request reports nonzero total");

endmodule
